>>> src/rgb_median_window_filter_assert.svh
// ---------------------------------------------------------------------------
// rgb_median_window_filter assertion macros
// Concurrent assertion wrappers; clocked on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef RGB_MEDIAN_WINDOW_FILTER_ASSERT_SVH
`define RGB_MEDIAN_WINDOW_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
`define RMWF_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmwf assertion failed");
`define RMWF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmwf assertion failed");
`else
`define RMWF_ASSERT_IMPLY(lbl, ante, cons)
`define RMWF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> src/rmwf_pkg.sv
// ---------------------------------------------------------------------------
// rmwf_pkg
// Shared types and constants of the RGB median window filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmwf_pkg;

	localparam int MAX_WIDTH_DEF  = 128;
	localparam int MAX_HEIGHT_DEF = 128;
	localparam int MAX_WINDOW     = 7;

	localparam int CH_W    = 8;
	localparam int PIX_W   = 3 * CH_W;
	localparam int NUM_CH  = 3;
	localparam int COORD_W = 7;
	localparam int CUR_W   = 8;
	localparam int DIM_W   = 8;
	localparam int WS_W    = 3;
	localparam int RAD_W   = 2;
	localparam int CNT_W   = 6;
	localparam int CFG_IDX_W = 2;

	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

	localparam logic [WS_W-1:0]  WINDOW_SIZE_RST  = 3'd3;
	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 8'd128;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 8'd128;

	localparam logic ACT_STORE  = 1'b0;
	localparam logic ACT_FILTER = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clear;
		logic sample;
		logic decide;
	} sel_ctl_t;

endpackage

>>> src/rmwf_ram.sv
// ---------------------------------------------------------------------------
// rmwf_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmwf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> src/rmwf_select.sv
// ---------------------------------------------------------------------------
// rmwf_select
// Bitwise radix selection of the middle element, one lane per channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmwf_select (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  rmwf_pkg::sel_ctl_t                        ctl,
	input  logic [rmwf_pkg::PIX_W-1:0]                pixel,
	output logic [rmwf_pkg::NUM_CH-1:0][rmwf_pkg::CH_W-1:0] med,
	output logic [rmwf_pkg::CNT_W-1:0]                n,
	output logic                                      last_pass
);

	logic [rmwf_pkg::CH_W-1:0]  bit_q;
	logic [rmwf_pkg::CH_W-1:0]  mask_q;
	logic [rmwf_pkg::CNT_W-1:0] n_q;
	logic [rmwf_pkg::CH_W-1:0]  pre_q [rmwf_pkg::NUM_CH];
	logic [rmwf_pkg::CNT_W-1:0] k_q   [rmwf_pkg::NUM_CH];
	logic [rmwf_pkg::CNT_W-1:0] cnt_q [rmwf_pkg::NUM_CH];
	logic [rmwf_pkg::CH_W-1:0]  val   [rmwf_pkg::NUM_CH];
	logic                       hit   [rmwf_pkg::NUM_CH];
	logic [rmwf_pkg::CNT_W-1:0] k_cur [rmwf_pkg::NUM_CH];
	logic                       first_pass;

	assign first_pass = bit_q[rmwf_pkg::CH_W-1];
	assign last_pass  = bit_q[0];
	assign n          = n_q;

	always_comb begin
		for (int i = 0; i < rmwf_pkg::NUM_CH; i++) begin
			val[i]   = pixel[rmwf_pkg::PIX_W-1-rmwf_pkg::CH_W*i -: rmwf_pkg::CH_W];
			hit[i]   = (((val[i] ^ pre_q[i]) & mask_q) == '0) && ((val[i] & bit_q) == '0);
			k_cur[i] = first_pass ? (n_q >> 1) : k_q[i];
			med[i]   = pre_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			mask_q <= '0;
			n_q    <= '0;
			for (int i = 0; i < rmwf_pkg::NUM_CH; i++) begin
				pre_q[i] <= '0;
				k_q[i]   <= '0;
				cnt_q[i] <= '0;
			end
		end else if (ctl.clear) begin
			bit_q  <= {1'b1, {(rmwf_pkg::CH_W-1){1'b0}}};
			mask_q <= '0;
			n_q    <= '0;
			for (int i = 0; i < rmwf_pkg::NUM_CH; i++) begin
				pre_q[i] <= '0;
				k_q[i]   <= '0;
				cnt_q[i] <= '0;
			end
		end else if (ctl.decide) begin
			// bit set when the rank lies at or past the zero-bit group
			bit_q  <= bit_q >> 1;
			mask_q <= mask_q | bit_q;
			for (int i = 0; i < rmwf_pkg::NUM_CH; i++) begin
				cnt_q[i] <= '0;
				if (k_cur[i] >= cnt_q[i]) begin
					pre_q[i] <= pre_q[i] | bit_q;
					k_q[i]   <= k_cur[i] - cnt_q[i];
				end else begin
					k_q[i] <= k_cur[i];
				end
			end
		end else if (ctl.sample) begin
			if (first_pass) begin
				n_q <= n_q + 1'b1;
			end
			for (int i = 0; i < rmwf_pkg::NUM_CH; i++) begin
				if (hit[i]) begin
					cnt_q[i] <= cnt_q[i] + 1'b1;
				end
			end
		end
	end

endmodule

>>> src/rgb_median_window_filter.sv
// ---------------------------------------------------------------------------
// rgb_median_window_filter
// Pixel store with per-channel median over a clipped square window.
// ---------------------------------------------------------------------------
// A store request writes one pixel and a request outside the frame returns
// an error; both go from acceptance through the finish state to the output
// register. A filter request works on a clipped window of n pixels (at most
// 7x7 window): the median is found one bit per pass, MSB first, and each of
// the eight passes reads the n window pixels through the single port of the
// pixel store, one per cycle, counting all three channels at once. One
// request is in work at a time; the next is taken as soon as the result sits
// in the output register. The store is not cleared at reset.
`timescale 1ns / 1ps

`include "rgb_median_window_filter_assert.svh"

module rgb_median_window_filter #(
	parameter int MAX_WIDTH  = rmwf_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rmwf_pkg::MAX_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rmwf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rmwf_pkg::DIM_W-1:0]         cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// row[6:0], col[13:7], red_in[21:14], green_in[29:22], blue_in[37:30]
	input  logic [rmwf_pkg::S_DATA_W-1:0]      s_tdata,
	// action[0]
	input  logic [0:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// red_out[7:0], green_out[15:8], blue_out[23:16], window_count[29:24]
	output logic [rmwf_pkg::M_DATA_W-1:0]      m_tdata,
	// status[0]
	output logic [0:0]                         m_tuser
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rmwf_pkg::state_t state_q, state_d;

	logic [rmwf_pkg::WS_W-1:0]  window_size_q;
	logic [rmwf_pkg::DIM_W-1:0] frame_width_q;
	logic [rmwf_pkg::DIM_W-1:0] frame_height_q;

	logic [rmwf_pkg::DIM_W-1:0]   w_eff, h_eff;
	logic [rmwf_pkg::WS_W-1:0]    size_cap;
	logic [rmwf_pkg::RAD_W-1:0]   rad;
	logic [rmwf_pkg::COORD_W-1:0] in_row, in_col;
	logic                         in_action;
	logic                         in_frame;
	logic [rmwf_pkg::CUR_W-1:0]   in_row_w, in_col_w, rad_w;
	logic [rmwf_pkg::CUR_W-1:0]   win_r0, win_r1, win_c0, win_c1;
	logic [rmwf_pkg::CUR_W-1:0]   row_hi, col_hi;

	logic [rmwf_pkg::CUR_W-1:0] r_q, c_q, r0_q, r1_q, c0_q, c1_q;
	logic                       err_q, filt_q;
	logic                       rd_vld_s1;
	logic                       start, load, last_addr;
	logic                       accept;

	logic                       ram_we;
	logic [AW-1:0]              ram_addr;
	logic [rmwf_pkg::PIX_W-1:0] ram_wdata, ram_rdata;

	rmwf_pkg::sel_ctl_t ctl;
	logic [rmwf_pkg::NUM_CH-1:0][rmwf_pkg::CH_W-1:0] med;
	logic [rmwf_pkg::CNT_W-1:0] n;
	logic                       last_pass;

	logic                       m_tvalid_q;
	logic [rmwf_pkg::M_DATA_W-1:0] m_tdata_q;
	logic                       status_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q  <= rmwf_pkg::WINDOW_SIZE_RST;
			frame_width_q  <= rmwf_pkg::FRAME_WIDTH_RST;
			frame_height_q <= rmwf_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rmwf_pkg::CFG_WINDOW_SIZE: begin
					window_size_q <= cfg_data[rmwf_pkg::WS_W-1:0];
				end
				rmwf_pkg::CFG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
				end
				rmwf_pkg::CFG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// request decode and window bounds
	always_comb begin
		in_row    = s_tdata[6:0];
		in_col    = s_tdata[13:7];
		in_action = s_tuser[0];
		w_eff = (32'(frame_width_q) > MAX_WIDTH) ? rmwf_pkg::DIM_W'(MAX_WIDTH) : frame_width_q;
		h_eff = (32'(frame_height_q) > MAX_HEIGHT) ? rmwf_pkg::DIM_W'(MAX_HEIGHT)
			: frame_height_q;
		in_frame = ({1'b0, in_row} < h_eff) && ({1'b0, in_col} < w_eff);
		size_cap = (32'(window_size_q) > rmwf_pkg::MAX_WINDOW)
			? rmwf_pkg::WS_W'(rmwf_pkg::MAX_WINDOW) : window_size_q;
		rad = (size_cap == '0) ? '0 : rmwf_pkg::RAD_W'((size_cap - 1'b1) >> 1);
		in_row_w = {1'b0, in_row};
		in_col_w = {1'b0, in_col};
		rad_w    = rmwf_pkg::CUR_W'(rad);
		win_r0 = (in_row_w >= rad_w) ? in_row_w - rad_w : '0;
		win_c0 = (in_col_w >= rad_w) ? in_col_w - rad_w : '0;
		row_hi = in_row_w + rad_w;
		col_hi = in_col_w + rad_w;
		win_r1 = (row_hi > h_eff - 1'b1) ? h_eff - 1'b1 : row_hi;
		win_c1 = (col_hi > w_eff - 1'b1) ? w_eff - 1'b1 : col_hi;
	end

	// sequencer
	assign s_tready  = (state_q == rmwf_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign last_addr = (r_q == r1_q) && (c_q == c1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rmwf_pkg::ST_IDLE;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == rmwf_pkg::ST_SCAN);
		end
	end

	always_comb begin
		state_d    = state_q;
		start      = 1'b0;
		load       = 1'b0;
		ctl        = '0;
		ctl.sample = rd_vld_s1;
		unique case (state_q)
			rmwf_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					start = 1'b1;
					if (in_frame && in_action == rmwf_pkg::ACT_FILTER) begin
						ctl.clear = 1'b1;
						state_d   = rmwf_pkg::ST_SCAN;
					end else begin
						state_d = rmwf_pkg::ST_FINISH;
					end
				end
			end
			rmwf_pkg::ST_SCAN: begin
				if (last_addr) begin
					state_d = rmwf_pkg::ST_DRAIN;
				end
			end
			rmwf_pkg::ST_DRAIN: begin
				state_d = rmwf_pkg::ST_DECIDE;
			end
			rmwf_pkg::ST_DECIDE: begin
				ctl.decide = 1'b1;
				state_d    = last_pass ? rmwf_pkg::ST_FINISH : rmwf_pkg::ST_SCAN;
			end
			rmwf_pkg::ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					load    = 1'b1;
					state_d = rmwf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rmwf_pkg::ST_IDLE;
			end
		endcase
	end

	// window cursor
	always_ff @(posedge clk) begin
		if (start) begin
			r0_q   <= win_r0;
			r1_q   <= win_r1;
			c0_q   <= win_c0;
			c1_q   <= win_c1;
			r_q    <= win_r0;
			c_q    <= win_c0;
			err_q  <= !in_frame;
			filt_q <= in_frame && (in_action == rmwf_pkg::ACT_FILTER);
		end else if (state_q == rmwf_pkg::ST_SCAN) begin
			if (c_q == c1_q) begin
				c_q <= c0_q;
				if (r_q != r1_q) begin
					r_q <= r_q + 1'b1;
				end
			end else begin
				c_q <= c_q + 1'b1;
			end
		end else if (state_q == rmwf_pkg::ST_DECIDE) begin
			r_q <= r0_q;
			c_q <= c0_q;
		end
	end

	// pixel store
	always_comb begin
		ram_we    = accept && in_frame && (in_action == rmwf_pkg::ACT_STORE);
		ram_wdata = s_tdata[37:14];
		ram_wdata = {s_tdata[21:14], s_tdata[29:22], s_tdata[37:30]};
		if (state_q == rmwf_pkg::ST_IDLE) begin
			ram_addr = AW'(32'(in_row) * MAX_WIDTH + 32'(in_col));
		end else begin
			ram_addr = AW'(32'(r_q) * MAX_WIDTH + 32'(c_q));
		end
	end

	rmwf_ram #(
		.WIDTH(rmwf_pkg::PIX_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	rmwf_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.pixel    (ram_rdata),
		.med      (med),
		.n        (n),
		.last_pass(last_pass)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= err_q ? rmwf_pkg::STATUS_RANGE : rmwf_pkg::STATUS_OK;
			if (filt_q) begin
				m_tdata_q <= {2'b00, n, med[2], med[1], med[0]};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = status_q;

	`RMWF_ASSERT_IMPLY(a_rd_in_scan, rd_vld_s1, (state_q == rmwf_pkg::ST_SCAN || state_q == rmwf_pkg::ST_DRAIN))
	`RMWF_ASSERT_IMPLY(a_cursor_bound, (state_q == rmwf_pkg::ST_SCAN), (r_q <= r1_q && c_q <= c1_q && r0_q <= r_q && c0_q <= c_q))
	`RMWF_ASSERT_IMPLY(a_window_nonempty, (state_q == rmwf_pkg::ST_FINISH && filt_q), (n != '0))
	`RMWF_ASSERT_NEXT(a_load_valid, load, (m_tvalid && state_q == rmwf_pkg::ST_IDLE))

endmodule
